>>> rtl/euler_camera_pose_unit_top_defines.svh
// Assertion macros shared by the camera pose unit RTL.
`ifndef EULER_CAMERA_POSE_UNIT_TOP_DEFINES_SVH
`define EULER_CAMERA_POSE_UNIT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check b in the same cycle whenever a holds.
`define ECP_ASSERT_NOW(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("camera pose unit: same-cycle check failed");
// Check b in the cycle after a holds.
`define ECP_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("camera pose unit: next-cycle check failed");
`else
`define ECP_ASSERT_NOW(lbl, clk, rst_n, a, b)
`define ECP_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

>>> rtl/ecpu_pkg.sv
// Types, codes and constant tables of the camera pose unit.
package ecpu_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOOK_X,
        ST_LOOK_Y,
        ST_LOOK_P,
        ST_ANG_PREP,
        ST_ANG_X,
        ST_ANG_XS,
        ST_ANG_SQ,
        ST_ANG_X2,
        ST_TERM_MUL,
        ST_TERM_REC,
        ST_TERM_QD,
        ST_TERM_COR,
        ST_ANG_FIN,
        ST_VEC,
        ST_MOVE_S,
        ST_MOVE_L,
        ST_MOVE,
        ST_DONE
    } t_state;

    // operation codes
    localparam logic [1:0] OP_LOOK = 2'd0;
    localparam logic [1:0] OP_MOVE = 2'd1;
    localparam logic [1:0] OP_SET  = 2'd2;

    // move direction codes
    localparam logic [2:0] DIR_FWD   = 3'd0;
    localparam logic [2:0] DIR_BACK  = 3'd1;
    localparam logic [2:0] DIR_RIGHT = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_UP    = 3'd4;
    localparam logic [2:0] DIR_DOWN  = 3'd5;

    // angles in 1/128 degree
    localparam logic signed [16:0] FULL_TURN   = 17'sd46080;
    localparam logic signed [14:0] PITCH_LIMIT = 15'sd11392;
    localparam logic [15:0] QUARTER_U = 16'd11520;
    localparam logic [15:0] HALF_U    = 16'd23040;
    localparam logic [15:0] THREEQ_U  = 16'd34560;
    localparam logic [15:0] EIGHTH_U  = 16'd5760;
    localparam logic [15:0] YAW_RESET   = 16'd40960;
    localparam logic signed [14:0] PITCH_RESET = -15'sd3840;
    localparam logic [15:0] SENS_RESET  = 16'd26;

    // radians per 1/128 degree, Q2.30 with 10 extra bits
    localparam logic [31:0] RAD_K = 32'd149922641;
    localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;

    // Taylor term divisors, sin and cos interleaved per term
    localparam logic [7:0] DIV_D [12] = '{
        8'd6, 8'd2, 8'd20, 8'd12, 8'd42, 8'd30,
        8'd72, 8'd56, 8'd110, 8'd90, 8'd156, 8'd132
    };
    // reciprocal shift: 31 plus floor(log2(divisor))
    localparam logic [5:0] DIV_SH [12] = '{
        6'd33, 6'd32, 6'd35, 6'd34, 6'd36, 6'd35,
        6'd37, 6'd36, 6'd37, 6'd37, 6'd38, 6'd38
    };
    // reciprocal: floor(2^shift / divisor), at most 2^31
    localparam logic [31:0] DIV_M [12] = '{
        32'((64'd1 << 33) / 64'd6),   32'((64'd1 << 32) / 64'd2),
        32'((64'd1 << 35) / 64'd20),  32'((64'd1 << 34) / 64'd12),
        32'((64'd1 << 36) / 64'd42),  32'((64'd1 << 35) / 64'd30),
        32'((64'd1 << 37) / 64'd72),  32'((64'd1 << 36) / 64'd56),
        32'((64'd1 << 37) / 64'd110), 32'((64'd1 << 37) / 64'd90),
        32'((64'd1 << 38) / 64'd156), 32'((64'd1 << 38) / 64'd132)
    };

endpackage

>>> rtl/euler_camera_pose_unit_top.sv
// Camera pose unit: look, move and set items over one shared 33x33 multiplier.
// A look item (all but the first, which only reports) runs two sin/cos Taylor
// series and 8 vector products; a move item steps the three position axes.
// One item at a time; the next is taken once the sequencer is back at idle,
// even while the previous result still waits at the output register.
// Reset is synchronous, active low; after reset a pass computes the
// vectors from the reset angles, and no item is accepted during it.
`include "euler_camera_pose_unit_top_defines.svh"

module euler_camera_pose_unit_top #(
    parameter int VECTOR_FRAC_BITS   = 14,
    parameter int POSITION_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic signed [15:0] i_delta_x,
    input  logic signed [15:0] i_delta_y,
    input  logic [2:0]         i_direction,
    input  logic [15:0]        i_move_speed,
    input  logic [15:0]        i_time_step,
    input  logic signed [31:0] i_new_x,
    input  logic signed [31:0] i_new_y,
    input  logic signed [31:0] i_new_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [15:0] o_look_x,
    output logic signed [15:0] o_look_y,
    output logic signed [15:0] o_look_z,
    output logic signed [15:0] o_up_x,
    output logic signed [15:0] o_up_y,
    output logic signed [15:0] o_up_z,
    output logic [15:0]        o_heading,
    output logic signed [14:0] o_elevation
);

    localparam int VW     = VECTOR_FRAC_BITS + 2;
    localparam int VEC_SH = 60 - VECTOR_FRAC_BITS;
    localparam int MOV_SH = VECTOR_FRAC_BITS + 24 - POSITION_FRAC_BITS;
    localparam logic signed [VW-1:0] VEC_ONE = VW'(1) << VECTOR_FRAC_BITS;
    localparam logic signed [31:0] POS_X_RESET =
        32'(-(64'sd5 <<< (POSITION_FRAC_BITS - 1)));
    localparam logic signed [31:0] POS_YZ_RESET =
        32'(((64'sd23 <<< POSITION_FRAC_BITS) + 64'sd5) / 64'sd10);
    localparam logic signed [65:0] POS_MAX = 66'sd2147483647;
    localparam logic signed [65:0] POS_MIN = -66'sd2147483648;

    ecpu_pkg::t_state r_state, n_state;

    logic               r_boot, r_seen, r_which, r_out_valid;
    logic [15:0]        r_sens;
    logic [15:0]        r_yaw;
    logic signed [14:0] r_pitch;
    logic signed [31:0] r_pos [3];
    logic signed [VW-1:0] r_vec [8];

    logic signed [15:0] r_dx, r_dy;
    logic [2:0]         r_dir;
    logic [15:0]        r_speed, r_dt;

    logic signed [65:0] r_prod;
    logic [12:0]        r_t;
    logic [1:0]         r_quad;
    logic               r_swap;
    logic [29:0]        r_x, r_x2, r_n, r_q0;
    logic [30:0]        r_st, r_ct;
    logic signed [32:0] r_ss, r_cs;
    logic signed [32:0] r_sy, r_cy, r_sp, r_cp;
    logic [3:0]         r_j;
    logic [3:0]         r_idx;
    logic [31:0]        r_scale;

    logic signed [31:0] r_o_pos [3];
    logic signed [15:0] r_o_look [3];
    logic signed [15:0] r_o_up [3];
    logic [15:0]        r_o_heading;
    logic signed [14:0] r_o_elev;

    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    logic               w_out_free;

    // shared multiplier, registered
    assign w_prod = 66'(w_ma) * 66'(w_mb);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ecpu_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_operation)
                        ecpu_pkg::OP_LOOK:
                            n_state = r_seen ? ecpu_pkg::ST_LOOK_X : ecpu_pkg::ST_DONE;
                        ecpu_pkg::OP_MOVE:
                            n_state = (i_direction <= ecpu_pkg::DIR_DOWN) ?
                                ecpu_pkg::ST_MOVE_S : ecpu_pkg::ST_DONE;
                        default: n_state = ecpu_pkg::ST_DONE;
                    endcase
                end
            end
            ecpu_pkg::ST_LOOK_X:   n_state = ecpu_pkg::ST_LOOK_Y;
            ecpu_pkg::ST_LOOK_Y:   n_state = ecpu_pkg::ST_LOOK_P;
            ecpu_pkg::ST_LOOK_P:   n_state = ecpu_pkg::ST_ANG_PREP;
            ecpu_pkg::ST_ANG_PREP: n_state = ecpu_pkg::ST_ANG_X;
            ecpu_pkg::ST_ANG_X:    n_state = ecpu_pkg::ST_ANG_XS;
            ecpu_pkg::ST_ANG_XS:   n_state = ecpu_pkg::ST_ANG_SQ;
            ecpu_pkg::ST_ANG_SQ:   n_state = ecpu_pkg::ST_ANG_X2;
            ecpu_pkg::ST_ANG_X2:   n_state = ecpu_pkg::ST_TERM_MUL;
            ecpu_pkg::ST_TERM_MUL: n_state = ecpu_pkg::ST_TERM_REC;
            ecpu_pkg::ST_TERM_REC: n_state = ecpu_pkg::ST_TERM_QD;
            ecpu_pkg::ST_TERM_QD:  n_state = ecpu_pkg::ST_TERM_COR;
            ecpu_pkg::ST_TERM_COR:
                n_state = (r_j == 4'd11) ? ecpu_pkg::ST_ANG_FIN : ecpu_pkg::ST_TERM_MUL;
            ecpu_pkg::ST_ANG_FIN:
                n_state = r_which ? ecpu_pkg::ST_VEC : ecpu_pkg::ST_ANG_PREP;
            ecpu_pkg::ST_VEC: begin
                if (r_idx == 4'd8)
                    n_state = r_boot ? ecpu_pkg::ST_IDLE : ecpu_pkg::ST_DONE;
            end
            ecpu_pkg::ST_MOVE_S:   n_state = ecpu_pkg::ST_MOVE_L;
            ecpu_pkg::ST_MOVE_L:   n_state = ecpu_pkg::ST_MOVE;
            ecpu_pkg::ST_MOVE: begin
                if (r_idx == 4'd3) n_state = ecpu_pkg::ST_DONE;
            end
            ecpu_pkg::ST_DONE: begin
                if (w_out_free) n_state = ecpu_pkg::ST_IDLE;
            end
            default: n_state = ecpu_pkg::ST_IDLE;
        endcase
    end

    // move direction vector
    logic signed [VW-1:0] w_mv [3];
    always_comb begin
        w_mv[0] = '0;
        w_mv[1] = '0;
        w_mv[2] = '0;
        case (r_dir)
            ecpu_pkg::DIR_FWD: begin
                w_mv[0] = r_vec[3];
                w_mv[2] = r_vec[4];
            end
            ecpu_pkg::DIR_BACK: begin
                w_mv[0] = -r_vec[3];
                w_mv[2] = -r_vec[4];
            end
            ecpu_pkg::DIR_RIGHT: begin
                w_mv[0] = -r_vec[4];
                w_mv[2] = r_vec[3];
            end
            ecpu_pkg::DIR_LEFT: begin
                w_mv[0] = r_vec[4];
                w_mv[2] = -r_vec[3];
            end
            ecpu_pkg::DIR_UP:   w_mv[1] = VEC_ONE;
            ecpu_pkg::DIR_DOWN: w_mv[1] = -VEC_ONE;
            default: ;
        endcase
    end

    // quotient estimate from the reciprocal product
    logic [29:0] w_q0;
    assign w_q0 = 30'(r_prod >>> ecpu_pkg::DIV_SH[r_j]);

    // outputs of the sequencer: multiplier operands and input stall
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ecpu_pkg::ST_LOOK_X: begin
                w_ma = 33'(r_dx);
                w_mb = 33'({1'b0, r_sens});
            end
            ecpu_pkg::ST_LOOK_Y: begin
                w_ma = 33'(r_dy);
                w_mb = 33'({1'b0, r_sens});
            end
            ecpu_pkg::ST_ANG_X: begin
                w_ma = 33'({1'b0, r_t});
                w_mb = 33'({1'b0, ecpu_pkg::RAD_K});
            end
            ecpu_pkg::ST_ANG_SQ: begin
                w_ma = 33'({1'b0, r_x});
                w_mb = 33'({1'b0, r_x});
            end
            ecpu_pkg::ST_TERM_MUL: begin
                w_ma = r_j[0] ? 33'({1'b0, r_ct}) : 33'({1'b0, r_st});
                w_mb = 33'({1'b0, r_x2});
            end
            ecpu_pkg::ST_TERM_REC: begin
                w_ma = 33'({1'b0, r_prod[59:30]});
                w_mb = 33'({1'b0, ecpu_pkg::DIV_M[r_j]});
            end
            ecpu_pkg::ST_TERM_QD: begin
                w_ma = 33'({1'b0, w_q0});
                w_mb = 33'({1'b0, ecpu_pkg::DIV_D[r_j]});
            end
            ecpu_pkg::ST_VEC: begin
                case (r_idx)
                    4'd0: begin w_ma = r_cy;  w_mb = r_cp; end
                    4'd1: begin w_ma = r_sp;  w_mb = ecpu_pkg::ONE_Q30; end
                    4'd2: begin w_ma = r_sy;  w_mb = r_cp; end
                    4'd3: begin w_ma = r_cy;  w_mb = ecpu_pkg::ONE_Q30; end
                    4'd4: begin w_ma = r_sy;  w_mb = ecpu_pkg::ONE_Q30; end
                    4'd5: begin w_ma = -r_cy; w_mb = r_sp; end
                    4'd6: begin w_ma = r_cp;  w_mb = ecpu_pkg::ONE_Q30; end
                    4'd7: begin w_ma = -r_sy; w_mb = r_sp; end
                    default: ;
                endcase
            end
            ecpu_pkg::ST_MOVE_S: begin
                w_ma = 33'({1'b0, r_speed});
                w_mb = 33'({1'b0, r_dt});
            end
            ecpu_pkg::ST_MOVE: begin
                if (r_idx < 4'd3) begin
                    w_ma = 33'(w_mv[r_idx[1:0]]);
                    w_mb = 33'({1'b0, r_scale});
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != ecpu_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // round half away from zero for vectors and position steps, saturate positions
    logic [65:0]          w_mag, w_rv, w_rm;
    logic signed [VW-1:0] w_vec_rnd;
    logic signed [65:0]   w_step, w_psum;
    logic signed [31:0]   w_pos_sat;
    logic [2:0]           w_slot;
    always_comb begin
        w_mag     = r_prod[65] ? 66'(-r_prod) : 66'(r_prod);
        w_rv      = (w_mag + (66'd1 << (VEC_SH - 1))) >> VEC_SH;
        w_rm      = (w_mag + (66'd1 << (MOV_SH - 1))) >> MOV_SH;
        w_vec_rnd = r_prod[65] ? -VW'(w_rv) : VW'(w_rv);
        w_step    = r_prod[65] ? -$signed(w_rm) : $signed(w_rm);
        w_slot    = 3'(r_idx - 4'd1);
        w_psum    = 66'(r_pos[w_slot[1:0]]) + w_step;
        if (w_psum > POS_MAX)      w_pos_sat = 32'(POS_MAX);
        else if (w_psum < POS_MIN) w_pos_sat = 32'(POS_MIN);
        else                       w_pos_sat = 32'(w_psum);
    end

    // wrap yaw, clamp pitch
    logic signed [65:0] w_ysum, w_pnew;
    logic [15:0]        w_yaw_new;
    logic signed [14:0] w_pitch_new;
    always_comb begin
        w_ysum = 66'($signed({1'b0, r_yaw})) + (r_prod >>> 1);
        if (w_ysum >= 66'(ecpu_pkg::FULL_TURN))  w_yaw_new = '0;
        else if (w_ysum <= 66'sd0)               w_yaw_new = 16'(ecpu_pkg::FULL_TURN);
        else                                     w_yaw_new = 16'(w_ysum);
        w_pnew = 66'(r_pitch) + ((-r_prod) >>> 1);
        if (w_pnew > 66'(ecpu_pkg::PITCH_LIMIT))
            w_pitch_new = ecpu_pkg::PITCH_LIMIT;
        else if (w_pnew < -66'(ecpu_pkg::PITCH_LIMIT))
            w_pitch_new = -ecpu_pkg::PITCH_LIMIT;
        else
            w_pitch_new = 15'(w_pnew);
    end

    // reduce angle to quadrant and octant
    logic signed [16:0] w_a, w_a2;
    logic [15:0]        w_red, w_rq;
    logic [1:0]         w_quad;
    always_comb begin
        w_a = r_which ? 17'(r_pitch) : $signed({1'b0, r_yaw});
        if (w_a < 17'sd0)                     w_a2 = w_a + ecpu_pkg::FULL_TURN;
        else if (w_a >= ecpu_pkg::FULL_TURN)  w_a2 = w_a - ecpu_pkg::FULL_TURN;
        else                                  w_a2 = w_a;
        w_red = w_a2[15:0];
        if (w_red >= ecpu_pkg::THREEQ_U) begin
            w_quad = 2'd3;
            w_rq   = w_red - ecpu_pkg::THREEQ_U;
        end else if (w_red >= ecpu_pkg::HALF_U) begin
            w_quad = 2'd2;
            w_rq   = w_red - ecpu_pkg::HALF_U;
        end else if (w_red >= ecpu_pkg::QUARTER_U) begin
            w_quad = 2'd1;
            w_rq   = w_red - ecpu_pkg::QUARTER_U;
        end else begin
            w_quad = 2'd0;
            w_rq   = w_red;
        end
    end

    // remainder check and corrected Taylor term
    logic [31:0]        w_rem;
    logic [30:0]        w_q;
    logic signed [32:0] w_qs;
    always_comb begin
        w_rem = 32'({2'b00, r_n}) - r_prod[31:0];
        w_q   = (w_rem >= 32'(ecpu_pkg::DIV_D[r_j])) ? 31'(r_q0) + 31'd1 : 31'(r_q0);
        w_qs  = $signed({2'b00, w_q});
    end

    // map octant result to the quadrant
    logic signed [32:0] w_bs, w_bc, w_s, w_c;
    always_comb begin
        w_bs = r_swap ? r_cs : r_ss;
        w_bc = r_swap ? r_ss : r_cs;
        case (r_quad)
            2'd0: begin w_s = w_bs;  w_c = w_bc;  end
            2'd1: begin w_s = w_bc;  w_c = -w_bs; end
            2'd2: begin w_s = -w_bs; w_c = -w_bc; end
            default: begin w_s = -w_bc; w_c = w_bs; end
        endcase
    end

    // datapath and control registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (!i_rst_n) begin
            r_state     <= ecpu_pkg::ST_ANG_PREP;
            r_boot      <= 1'b1;
            r_which     <= 1'b0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
            r_sens      <= ecpu_pkg::SENS_RESET;
            r_yaw       <= ecpu_pkg::YAW_RESET;
            r_pitch     <= ecpu_pkg::PITCH_RESET;
            r_pos[0]    <= POS_X_RESET;
            r_pos[1]    <= POS_YZ_RESET;
            r_pos[2]    <= POS_YZ_RESET;
            r_j         <= '0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_sens <= i_cfg_data;
            // drop the result once taken unless a new one loads now
            if (r_out_valid && !i_out_stall &&
                !((r_state == ecpu_pkg::ST_DONE) && w_out_free))
                r_out_valid <= 1'b0;
            case (r_state)
                ecpu_pkg::ST_IDLE: begin
                    if (i_in_valid) begin
                        r_dx    <= i_delta_x;
                        r_dy    <= i_delta_y;
                        r_dir   <= i_direction;
                        r_speed <= i_move_speed;
                        r_dt    <= i_time_step;
                        if (i_operation == ecpu_pkg::OP_LOOK) r_seen <= 1'b1;
                        if (i_operation == ecpu_pkg::OP_SET) begin
                            r_pos[0] <= i_new_x;
                            r_pos[1] <= i_new_y;
                            r_pos[2] <= i_new_z;
                        end
                    end
                end
                ecpu_pkg::ST_LOOK_Y: r_yaw <= w_yaw_new;
                ecpu_pkg::ST_LOOK_P: begin
                    r_pitch <= w_pitch_new;
                    r_which <= 1'b0;
                end
                ecpu_pkg::ST_ANG_PREP: begin
                    r_quad <= w_quad;
                    r_swap <= (w_rq > ecpu_pkg::EIGHTH_U);
                    r_t    <= (w_rq > ecpu_pkg::EIGHTH_U) ?
                        13'(ecpu_pkg::QUARTER_U - w_rq) : 13'(w_rq);
                end
                ecpu_pkg::ST_ANG_XS: r_x <= 30'((r_prod + 66'sd512) >>> 10);
                ecpu_pkg::ST_ANG_X2: begin
                    r_x2 <= 30'((r_prod + 66'sd536870912) >>> 30);
                    r_st <= 31'(r_x);
                    r_ct <= 31'(ecpu_pkg::ONE_Q30);
                    r_ss <= $signed({3'b000, r_x});
                    r_cs <= ecpu_pkg::ONE_Q30;
                    r_j  <= '0;
                end
                ecpu_pkg::ST_TERM_REC: r_n  <= r_prod[59:30];
                ecpu_pkg::ST_TERM_QD:  r_q0 <= w_q0;
                ecpu_pkg::ST_TERM_COR: begin
                    // odd terms subtract, even terms add
                    if (r_j[0]) begin
                        r_ct <= w_q;
                        r_cs <= r_j[1] ? r_cs + w_qs : r_cs - w_qs;
                    end else begin
                        r_st <= w_q;
                        r_ss <= r_j[1] ? r_ss + w_qs : r_ss - w_qs;
                    end
                    r_j <= r_j + 4'd1;
                end
                ecpu_pkg::ST_ANG_FIN: begin
                    if (r_which) begin
                        r_sp  <= w_s;
                        r_cp  <= w_c;
                        r_idx <= '0;
                    end else begin
                        r_sy    <= w_s;
                        r_cy    <= w_c;
                        r_which <= 1'b1;
                    end
                end
                ecpu_pkg::ST_VEC: begin
                    if (r_idx != 4'd0) r_vec[w_slot] <= w_vec_rnd;
                    r_idx <= r_idx + 4'd1;
                    if (r_idx == 4'd8) r_boot <= 1'b0;
                end
                ecpu_pkg::ST_MOVE_L: begin
                    r_scale <= r_prod[31:0];
                    r_idx   <= '0;
                end
                ecpu_pkg::ST_MOVE: begin
                    if (r_idx != 4'd0) r_pos[w_slot[1:0]] <= w_pos_sat;
                    r_idx <= r_idx + 4'd1;
                end
                ecpu_pkg::ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_pos[0]  <= r_pos[0];
                        r_o_pos[1]  <= r_pos[1];
                        r_o_pos[2]  <= r_pos[2];
                        r_o_look[0] <= 16'(32'(r_vec[0]));
                        r_o_look[1] <= 16'(32'(r_vec[1]));
                        r_o_look[2] <= 16'(32'(r_vec[2]));
                        r_o_up[0]   <= 16'(32'(r_vec[5]));
                        r_o_up[1]   <= 16'(32'(r_vec[6]));
                        r_o_up[2]   <= 16'(32'(r_vec[7]));
                        r_o_heading <= r_yaw;
                        r_o_elev    <= r_pitch;
                    end
                end
                default: ;
            endcase
        end
    end

    // drive result ports
    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_o_pos[0];
    assign o_pos_y     = r_o_pos[1];
    assign o_pos_z     = r_o_pos[2];
    assign o_look_x    = r_o_look[0];
    assign o_look_y    = r_o_look[1];
    assign o_look_z    = r_o_look[2];
    assign o_up_x      = r_o_up[0];
    assign o_up_y      = r_o_up[1];
    assign o_up_z      = r_o_up[2];
    assign o_heading   = r_o_heading;
    assign o_elevation = r_o_elev;

    `ECP_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, (r_state == ecpu_pkg::ST_DONE) && w_out_free, r_out_valid)
    `ECP_ASSERT_NOW(a_rem_one_step, i_clk, i_rst_n, r_state == ecpu_pkg::ST_TERM_COR, w_rem < 32'({ecpu_pkg::DIV_D[r_j], 1'b0}))
    `ECP_ASSERT_NOW(a_pitch_range, i_clk, i_rst_n, 1'b1, (r_pitch <= ecpu_pkg::PITCH_LIMIT) && (r_pitch >= -ecpu_pkg::PITCH_LIMIT))
    `ECP_ASSERT_NOW(a_boot_quiet, i_clk, i_rst_n, r_boot, !r_out_valid && o_in_stall)

endmodule
